// ===== rtl/core/rcss_pkg.sv =====
// ----------------------------------------------------------------------------
// rcss_pkg
// Shared types and constants for the rotating color slot scroller.
// ----------------------------------------------------------------------------
package rcss_pkg;

  typedef enum logic {
    OP_RESTART = 1'b0,
    OP_TICK    = 1'b1
  } opcode_t;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned SPEED_W = 9;
  localparam int unsigned PHASE_W = 11;
  localparam int unsigned MS_W    = 8;
  localparam int unsigned PT_W    = 16;

  localparam logic [POS_W-1:0]   POS_LOW    = 13'd2500;
  localparam logic [POS_W-1:0]   POS_HIGH   = 13'd7500;
  localparam logic [PHASE_W-1:0] PH_UP_END  = 11'd300;
  localparam logic [PHASE_W-1:0] PH_HOLD1   = 11'd600;
  localparam logic [PHASE_W-1:0] PH_DN_END  = 11'd1200;
  localparam logic [PHASE_W-1:0] PH_HOLD2   = 11'd1500;
  localparam logic [PHASE_W-1:0] PH_END     = 11'd1800;
  localparam logic [MS_W-1:0]    MS_MAX     = 8'd255;
  localparam logic [MS_W-1:0]    INTV_RESET = 8'd5;
  localparam logic signed [PT_W-1:0] LAST_LIMIT = 16'sd17500;
  localparam logic signed [PT_W-1:0] STRIP_SPAN = 16'sd20000;
  localparam logic [1:0]         SLOT_LAST  = 2'd3;

  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    color_t [3:0]     col;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [PT_W-1:0] slot_offset(input logic [1:0] k);
    logic signed [PT_W-1:0] r;
    case (k)
      2'd0: r = 16'sd0;
      2'd1: r = 16'sd5000;
      2'd2: r = 16'sd10000;
      2'd3: r = 16'sd15000;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/rcss_front.sv =====
// ----------------------------------------------------------------------------
// rcss_front
// Accepts requests, counts ticks and runs the per-frame motion update.
// ----------------------------------------------------------------------------
module rcss_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [95:0]         in_tdata,
  input  logic                in_tuser,
  input  rcss_pkg::q_stat_t   q_stat,
  output logic                push,
  output rcss_pkg::frame_t    push_frame
);

  logic [rcss_pkg::MS_W-1:0]           intv_r;
  logic [rcss_pkg::MS_W-1:0]           ms_r, ms_nxt, ms_inc;
  logic [rcss_pkg::PHASE_W-1:0]        phase_r, phase_nxt, ph;
  logic signed [rcss_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic signed [rcss_pkg::SPEED_W-1:0] start_r, start_nxt;
  logic                                neg_r, neg_nxt;
  logic [rcss_pkg::POS_W-1:0]          pos_r, pos_nxt;
  rcss_pkg::color_t                    col_r [4];
  rcss_pkg::color_t                    col_nxt [4];
  logic                                accept, due, ramp_en, push_c;
  logic [rcss_pkg::PHASE_W-1:0]        t;
  logic signed [10:0]                  two_s, t_s, half, half_c;
  logic signed [14:0]                  pos_sum;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign ms_inc    = (ms_r < rcss_pkg::MS_MAX) ? ms_r + 8'd1 : ms_r;
  assign due       = ms_inc >= intv_r;
  assign ph        = phase_r + 11'd1;

  always_comb begin
    ramp_en = 1'b0;
    t       = '0;
    if (ph <= rcss_pkg::PH_UP_END) begin
      ramp_en = 1'b1;
      t       = ph;
    end else if (ph <= rcss_pkg::PH_HOLD1) begin
      ramp_en = 1'b0;
    end else if (ph <= rcss_pkg::PH_DN_END) begin
      ramp_en = 1'b1;
      t       = ph - rcss_pkg::PH_HOLD1;
    end else if (ph <= rcss_pkg::PH_HOLD2) begin
      ramp_en = 1'b0;
    end else if (ph < rcss_pkg::PH_END) begin
      ramp_en = 1'b1;
      t       = ph - rcss_pkg::PH_HOLD2;
    end
  end

  assign two_s   = $signed({{2{start_r[8]}}, start_r}) <<< 1;
  assign t_s     = $signed(t);
  assign half    = neg_r ? two_s - t_s : two_s + t_s;
  assign half_c  = half + $signed({10'd0, half[10]});

  always_comb begin
    ms_nxt    = ms_r;
    phase_nxt = phase_r;
    speed_nxt = speed_r;
    start_nxt = start_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    push_c    = 1'b0;
    pos_sum   = '0;
    for (int i = 0; i < 4; i++) col_nxt[i] = col_r[i];
    if (accept) begin
      if (in_tuser == rcss_pkg::OP_RESTART) begin
        ms_nxt    = '0;
        phase_nxt = '0;
        speed_nxt = '0;
        start_nxt = '0;
        neg_nxt   = 1'b0;
        pos_nxt   = rcss_pkg::POS_LOW;
        for (int i = 0; i < 4; i++) col_nxt[i] = in_tdata[i*24 +: 24];
      end else if (!due) begin
        ms_nxt = ms_inc;
      end else if (ph == rcss_pkg::PH_END) begin
        ms_nxt    = '0;
        phase_nxt = '0;
        speed_nxt = '0;
        start_nxt = '0;
        neg_nxt   = 1'b0;
      end else begin
        ms_nxt    = '0;
        phase_nxt = ph;
        push_c    = 1'b1;
        if (ramp_en) speed_nxt = half_c[9:1];
        if (ph == rcss_pkg::PH_UP_END) begin
          start_nxt = half_c[9:1];
          neg_nxt   = 1'b1;
        end else if (ph == rcss_pkg::PH_DN_END) begin
          start_nxt = half_c[9:1];
          neg_nxt   = 1'b0;
        end
        pos_sum = $signed({2'b00, pos_r}) + $signed({{6{speed_nxt[8]}}, speed_nxt});
        if (pos_sum > $signed({2'b00, rcss_pkg::POS_HIGH})) begin
          pos_nxt    = rcss_pkg::POS_LOW;
          col_nxt[2] = col_r[1];
          col_nxt[1] = col_r[0];
          col_nxt[0] = col_r[3];
          col_nxt[3] = in_tdata[23:0];
        end else if (pos_sum < $signed({2'b00, rcss_pkg::POS_LOW})) begin
          pos_nxt    = rcss_pkg::POS_HIGH;
          col_nxt[3] = col_r[0];
          col_nxt[0] = col_r[1];
          col_nxt[1] = col_r[2];
          col_nxt[2] = in_tdata[23:0];
        end else begin
          pos_nxt = pos_sum[12:0];
        end
      end
    end
  end

  assign push = push_c;
  always_comb begin
    push_frame.pos = pos_nxt;
    for (int i = 0; i < 4; i++) push_frame.col[i] = col_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intv_r  <= rcss_pkg::INTV_RESET;
      ms_r    <= '0;
      phase_r <= '0;
      speed_r <= '0;
      start_r <= '0;
      neg_r   <= 1'b0;
      pos_r   <= rcss_pkg::POS_LOW;
      for (int i = 0; i < 4; i++) col_r[i] <= '0;
    end else begin
      if (cfg_wr_en) intv_r <= cfg_wr_data;
      ms_r    <= ms_nxt;
      phase_r <= phase_nxt;
      speed_r <= speed_nxt;
      start_r <= start_nxt;
      neg_r   <= neg_nxt;
      pos_r   <= pos_nxt;
      for (int i = 0; i < 4; i++) col_r[i] <= col_nxt[i];
    end
  end

endmodule

// ===== rtl/core/rcss_queue.sv =====
// ----------------------------------------------------------------------------
// rcss_queue
// Two-entry frame queue between the front end and the point serializer.
// ----------------------------------------------------------------------------
module rcss_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rcss_pkg::frame_t  push_frame,
  input  logic              pop,
  output rcss_pkg::frame_t  head,
  output rcss_pkg::q_stat_t q_stat
);

  rcss_pkg::frame_t ent_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/rcss_back.sv =====
// ----------------------------------------------------------------------------
// rcss_back
// Serializes each queued frame into four point results.
// ----------------------------------------------------------------------------
module rcss_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rcss_pkg::frame_t  head,
  input  rcss_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,
  output logic              out_tlast
);

  logic [1:0]                       k_r, k_nxt;
  logic                             vld_r, vld_nxt;
  logic [1:0]                       slot_r;
  rcss_pkg::color_t                 color_r;
  logic signed [rcss_pkg::PT_W-1:0] ppos_r, ppos;
  logic                             last_r;
  logic                             load;

  assign load = !q_stat.empty && (!vld_r || out_tready);
  assign pop  = load && (k_r == rcss_pkg::SLOT_LAST);

  always_comb begin
    ppos = $signed({3'b000, head.pos}) + rcss_pkg::slot_offset(k_r);
    if (k_r == rcss_pkg::SLOT_LAST && ppos > rcss_pkg::LAST_LIMIT)
      ppos = ppos - rcss_pkg::STRIP_SPAN;
  end

  always_comb begin
    k_nxt   = load ? k_r + 2'd1 : k_r;
    vld_nxt = load ? 1'b1 : (vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r  <= k_r;
      color_r <= head.col[k_r];
      ppos_r  <= ppos;
      last_r  <= k_r == rcss_pkg::SLOT_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= '0;
      vld_r <= 1'b0;
    end else begin
      k_r   <= k_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {6'd0, ppos_r, color_r, slot_r};
  assign out_tlast  = last_r;

endmodule

// ===== rtl/core/rotating_color_slot_scroller.sv =====
// ----------------------------------------------------------------------------
// rotating_color_slot_scroller
// Four-point color scroller driven by restart requests and millisecond ticks.
// ----------------------------------------------------------------------------
// A request is taken in the cycle it arrives whenever the two-entry frame
// queue has room; the motion update for a frame finishes in that same cycle.
// Each frame leaves as four results from the output register of the point
// serializer, back to back while out_tready stays high; ticks that end no
// frame pass at one per cycle while the frame queue has room.
module rotating_color_slot_scroller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // frame_interval_ms
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,      // fresh_color_a, fresh_color_b, fresh_color_c, fresh_color_d
  input  logic        in_tuser,      // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // slot_index, point_color, point_position, zero pad
  output logic        out_tlast      // last_point
);

  rcss_pkg::q_stat_t q_stat;
  rcss_pkg::frame_t  push_frame, head;
  logic              push, pop;

  rcss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_stat     (q_stat),
    .push       (push),
    .push_frame (push_frame)
  );

  rcss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_frame(push_frame),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  rcss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// ===== rtl/core/rcss_checker.sv =====
// ----------------------------------------------------------------------------
// rcss_checker
// Port-level checks for the rotating color slot scroller.
// ----------------------------------------------------------------------------
module rcss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] == 2'd3)))
    else $error("tlast does not match the fourth point");

  a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[1:0] == $past(out_tdata[1:0]) + 2'd1))
    else $error("points of a frame not back to back in order");

  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'd0 |->
      $signed(out_tdata[41:26]) >= 16'sd2500 && $signed(out_tdata[41:26]) <= 16'sd7500)
    else $error("first point outside the wrap window");

endmodule

bind rotating_color_slot_scroller rcss_checker u_rcss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
